// ----- design/shlp_pkg.sv -----
// shlp_pkg: shared types, constants and the crypt table for the string hash table
// depends on nothing; used by every file of the block but shlp_ram
package shlp_pkg;

    // default slot count of the table
    localparam int TABLE_DEPTH_DEF = 1024;

    // crypt table generator and hash seeds
    localparam logic [31:0] LCG_START = 32'h0010_0001;
    localparam logic [31:0] LCG_MUL = 32'd125;
    localparam logic [31:0] LCG_MOD = 32'h002A_AAAB;
    localparam logic [31:0] LOW_MASK = 32'h0000_FFFF;
    localparam logic [31:0] SEED_ONE_INIT = 32'h7FED_7FED;
    localparam logic [31:0] SEED_TWO_INIT = 32'hEEEE_EEEE;

    localparam int CFG_W = 11;
    localparam int POS_W = 10;
    localparam logic [CFG_W-1:0] LEN_RESET = 11'd1024;

    // operation codes
    typedef enum logic [1:0] {
        FUNC_LOOKUP = 2'd0,
        FUNC_INSERT = 2'd1,
        FUNC_CLEAR  = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef struct packed {
        func_t      func;
        logic [7:0] key_byte;
        logic       last_byte;
    } cmd_t;

    typedef struct packed {
        logic             ok;
        logic [POS_W-1:0] position;
    } result_t;

    // one table slot as kept in memory
    typedef struct packed {
        logic        valid;
        logic [31:0] hash_a;
        logic [31:0] hash_b;
    } slot_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_CHECK
    } state_t;

    typedef logic [3*256-1:0][31:0] rom_t;

    function automatic logic [31:0] lcg_next(input logic [31:0] s);
        return (s * LCG_MUL + 32'd3) % LCG_MOD;
    endfunction

    function automatic rom_t build_rom();
        rom_t        r;
        logic [31:0] seed;
        logic [31:0] hi;
        r = '0;
        seed = LCG_START;
        for (int row = 0; row < 256; row++)
        begin
            for (int kind = 0; kind < 5; kind++)
            begin
                seed = lcg_next(seed);
                hi = (seed & LOW_MASK) << 16;
                seed = lcg_next(seed);
                if (kind < 3)
                begin
                    r[kind*256 + row] = hi | (seed & LOW_MASK);
                end
            end
        end
        return r;
    endfunction

    // crypt table: rows for offset hash, hash a and hash b
    localparam rom_t CRYPT_ROM = build_rom();

endpackage

// ----- design/shlp_ram.sv -----
// shlp_ram: generic single-port synchronous ram with registered read
// depends on nothing
module shlp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- design/string_hash_table_linear_probe.sv -----
// string_hash_table_linear_probe: top level, hashing, divider, probe sequencer
// depends on shlp_pkg and shlp_ram
//
//  channel  | ports                       | marks a word
//  ---------+-----------------------------+--------------------------
//  command  | start, busy, cmd            | start high, busy low
//  result   | done, result                | done high for one cycle
//  config   | cfg_we, cfg_wdata           | cfg_we high
//
// A key byte that is not last is folded in and leaves busy low. On the last
// byte the offset hash goes through a bit-serial divider, then each probe reads
// a slot through the slot memory's registered read port (ST_READ, then ST_CHECK),
// up to table_length probes. A clear answers in the next cycle, then sweeps every
// slot of the memory; the same sweep runs after reset with busy high.
// Results cannot be held off; done pulses once per lookup, insert or clear.
module string_hash_table_linear_probe #(
    parameter int TABLE_DEPTH = shlp_pkg::TABLE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  shlp_pkg::cmd_t                    cmd,
    output logic                              done,
    output shlp_pkg::result_t                 result,
    input  logic                              cfg_we,
    input  logic [shlp_pkg::CFG_W-1:0]        cfg_wdata
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int LW = $clog2(TABLE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

    shlp_pkg::state_t state_reg, state_next;
    logic [shlp_pkg::CFG_W-1:0] len_cfg_reg;
    logic [31:0] seed1_reg [3];
    logic [31:0] seed2_reg [3];
    logic [31:0] seed1_new [3];
    logic [31:0] seed2_new [3];
    logic [31:0] h0_reg, h0_next;
    logic [31:0] ha_reg, ha_next;
    logic [31:0] hb_reg, hb_next;
    logic        ins_reg, ins_next;
    logic [4:0]  bit_reg, bit_next;
    logic [LW-1:0] rem_reg, rem_next;
    logic [LW:0]   rem_shift;
    logic [AW-1:0] pos_reg, pos_next;
    logic [LW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic          done_reg, done_next;
    shlp_pkg::result_t result_reg, result_next;
    logic [LW-1:0] eff_len;
    logic [31:0]   len_wide;
    logic          accept;
    logic          key_done;
    logic          seed_reset;
    logic          hit;
    logic          wrap_end;
    logic [AW-1:0] pos_inc;
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    shlp_pkg::slot_t ram_wdata, ram_rdata;

    assign busy = (state_reg != shlp_pkg::ST_IDLE);
    assign accept = start && !busy;
    assign done = done_reg;
    assign result = result_reg;

    // effective table length, clamped to 1..TABLE_DEPTH
    always_comb
    begin
        len_wide = {21'd0, len_cfg_reg};
        if (len_wide == 32'd0)
        begin
            len_wide = 32'd1;
        end
        else if (len_wide > 32'(TABLE_DEPTH))
        begin
            len_wide = 32'(TABLE_DEPTH);
        end
        eff_len = LW'(len_wide);
    end

    // three running hashes absorb one byte; a zero byte leaves them as they are
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (cmd.key_byte == 8'd0)
            begin
                seed1_new[k] = seed1_reg[k];
                seed2_new[k] = seed2_reg[k];
            end
            else
            begin
                seed1_new[k] = shlp_pkg::CRYPT_ROM[{2'(k), cmd.key_byte}]
                               ^ (seed1_reg[k] + seed2_reg[k]);
                seed2_new[k] = {24'd0, cmd.key_byte} + seed1_new[k] + seed2_reg[k]
                               + (seed2_reg[k] << 5) + 32'd3;
            end
        end
    end

    assign key_done = accept && (cmd.func == shlp_pkg::FUNC_LOOKUP
                                 || cmd.func == shlp_pkg::FUNC_INSERT) && cmd.last_byte;
    assign seed_reset = accept && (cmd.func == shlp_pkg::FUNC_CLEAR || key_done);

    // probe decisions on the slot read back
    assign hit = ram_rdata.valid && ram_rdata.hash_a == ha_reg && ram_rdata.hash_b == hb_reg;
    assign wrap_end = (cnt_reg + LW'(1)) == eff_len;
    assign pos_inc = (LW'(pos_reg) + LW'(1) == eff_len) ? '0 : pos_reg + AW'(1);
    assign rem_shift = {rem_reg, h0_reg[bit_reg]};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            shlp_pkg::ST_CLEAR:
            begin
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = shlp_pkg::ST_IDLE;
                end
            end
            shlp_pkg::ST_IDLE:
            begin
                if (accept && cmd.func == shlp_pkg::FUNC_CLEAR)
                begin
                    state_next = shlp_pkg::ST_CLEAR;
                end
                else if (key_done)
                begin
                    state_next = shlp_pkg::ST_DIV;
                end
            end
            shlp_pkg::ST_DIV:
            begin
                if (bit_reg == 5'd0)
                begin
                    state_next = shlp_pkg::ST_READ;
                end
            end
            shlp_pkg::ST_READ:
            begin
                state_next = shlp_pkg::ST_CHECK;
            end
            shlp_pkg::ST_CHECK:
            begin
                if (!ram_rdata.valid || (!ins_reg && hit) || wrap_end)
                begin
                    state_next = shlp_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = shlp_pkg::ST_READ;
                end
            end
            default:
            begin
                state_next = shlp_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        h0_next = h0_reg;
        ha_next = ha_reg;
        hb_next = hb_reg;
        ins_next = ins_reg;
        bit_next = bit_reg;
        rem_next = rem_reg;
        pos_next = pos_reg;
        cnt_next = cnt_reg;
        clr_next = clr_reg;
        done_next = 1'b0;
        result_next = result_reg;
        ram_we = 1'b0;
        ram_addr = pos_reg;
        ram_wdata = '{valid: 1'b1, hash_a: ha_reg, hash_b: hb_reg};
        unique case (state_reg)
            shlp_pkg::ST_CLEAR:
            begin
                ram_we = 1'b1;
                ram_addr = clr_reg;
                ram_wdata = '0;
                clr_next = clr_reg + AW'(1);
            end
            shlp_pkg::ST_IDLE:
            begin
                if (accept && cmd.func == shlp_pkg::FUNC_CLEAR)
                begin
                    done_next = 1'b1;
                    result_next = '{ok: 1'b1, position: '0};
                    clr_next = '0;
                end
                else if (key_done)
                begin
                    h0_next = seed1_new[0];
                    ha_next = seed1_new[1];
                    hb_next = seed1_new[2];
                    ins_next = (cmd.func == shlp_pkg::FUNC_INSERT);
                    bit_next = 5'd31;
                    rem_next = '0;
                end
            end
            shlp_pkg::ST_DIV:
            begin
                // one restoring step per cycle
                if (rem_shift >= {1'b0, eff_len})
                begin
                    rem_next = LW'(rem_shift - {1'b0, eff_len});
                end
                else
                begin
                    rem_next = LW'(rem_shift);
                end
                bit_next = bit_reg - 5'd1;
                if (bit_reg == 5'd0)
                begin
                    pos_next = (rem_shift >= {1'b0, eff_len})
                               ? AW'(rem_shift - {1'b0, eff_len}) : AW'(rem_shift);
                    cnt_next = '0;
                end
            end
            shlp_pkg::ST_READ:
            begin
            end
            shlp_pkg::ST_CHECK:
            begin
                if (!ram_rdata.valid)
                begin
                    done_next = 1'b1;
                    if (ins_reg)
                    begin
                        ram_we = 1'b1;
                        result_next = '{ok: 1'b1, position: shlp_pkg::POS_W'(pos_reg)};
                    end
                    else
                    begin
                        result_next = '{ok: 1'b0, position: '0};
                    end
                end
                else if (!ins_reg && hit)
                begin
                    done_next = 1'b1;
                    result_next = '{ok: 1'b1, position: shlp_pkg::POS_W'(pos_reg)};
                end
                else if (wrap_end)
                begin
                    done_next = 1'b1;
                    result_next = '{ok: 1'b0, position: '0};
                end
                else
                begin
                    pos_next = pos_inc;
                    cnt_next = cnt_reg + LW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= shlp_pkg::ST_CLEAR;
            clr_reg <= '0;
            done_reg <= 1'b0;
            len_cfg_reg <= shlp_pkg::LEN_RESET;
            for (int k = 0; k < 3; k++)
            begin
                seed1_reg[k] <= shlp_pkg::SEED_ONE_INIT;
                seed2_reg[k] <= shlp_pkg::SEED_TWO_INIT;
            end
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            done_reg <= done_next;
            if (cfg_we)
            begin
                len_cfg_reg <= cfg_wdata;
            end
            for (int k = 0; k < 3; k++)
            begin
                if (seed_reset)
                begin
                    seed1_reg[k] <= shlp_pkg::SEED_ONE_INIT;
                    seed2_reg[k] <= shlp_pkg::SEED_TWO_INIT;
                end
                else if (accept && (cmd.func == shlp_pkg::FUNC_LOOKUP
                                    || cmd.func == shlp_pkg::FUNC_INSERT))
                begin
                    seed1_reg[k] <= seed1_new[k];
                    seed2_reg[k] <= seed2_new[k];
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        h0_reg <= h0_next;
        ha_reg <= ha_next;
        hb_reg <= hb_next;
        ins_reg <= ins_next;
        bit_reg <= bit_next;
        rem_reg <= rem_next;
        pos_reg <= pos_next;
        cnt_reg <= cnt_next;
        result_reg <= result_next;
    end

    // slot memory: valid flag and both stored hashes
    shlp_ram #(
        .WIDTH($bits(shlp_pkg::slot_t)),
        .DEPTH(TABLE_DEPTH)
    ) u_slots (
        .clk(clk),
        .we(ram_we),
        .addr(ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

endmodule

// ----- design/shlp_checker.sv -----
// shlp_checker: port-level assertions for the string hash table
// depends on shlp_pkg; bound to string_hash_table_linear_probe
module shlp_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input shlp_pkg::cmd_t    cmd,
    input logic              done,
    input shlp_pkg::result_t result
);

    // a clear answers at once and then sweeps
    a_clear_answer: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && cmd.func == shlp_pkg::FUNC_CLEAR
        |=> done && result.ok && result.position == '0 && busy)
        else $error("clear word not answered as expected");

    // a failed operation reports slot zero
    a_fail_pos: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.ok |-> result.position == '0)
        else $error("nonzero position with ok low");

    // inner key bytes leave busy low and give no result
    a_inner_byte: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !cmd.last_byte
        && (cmd.func == shlp_pkg::FUNC_LOOKUP || cmd.func == shlp_pkg::FUNC_INSERT)
        |=> !done && !busy)
        else $error("inner key byte stalled or answered");

    // the unused code is ignored
    a_unused: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && cmd.func == shlp_pkg::FUNC_NONE |=> !done && !busy)
        else $error("unused function code acted on");

    // last byte of a key starts a probe walk
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && cmd.last_byte
        && (cmd.func == shlp_pkg::FUNC_LOOKUP || cmd.func == shlp_pkg::FUNC_INSERT)
        |=> busy && !done)
        else $error("last key byte did not start a probe");

endmodule

bind string_hash_table_linear_probe shlp_checker u_shlp_checker (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .done(done),
    .result(result)
);

// ----- tb/sv/hash_table_checker.sv -----
// hash_table_checker: watches the command, result and config channels of the
// string hash table, predicts every result word and compares it field by field
// depends on shlp_pkg
module hash_table_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  shlp_pkg::cmd_t              cmd,
    input  logic                        done,
    input  shlp_pkg::result_t           result,
    input  logic                        cfg_we,
    input  logic [shlp_pkg::CFG_W-1:0]  cfg_wdata,
    output int                          fail_count,
    output int                          pending,
    output int                          results_seen
);

    localparam int SLOTS = shlp_pkg::TABLE_DEPTH_DEF;

    logic [31:0]                 crypt_words [3][256];
    logic [31:0]                 seed_one [3];
    logic [31:0]                 seed_two [3];
    bit                          slot_used [SLOTS];
    logic [31:0]                 slot_a [SLOTS];
    logic [31:0]                 slot_b [SLOTS];
    logic [shlp_pkg::CFG_W-1:0]  length_reg;
    shlp_pkg::result_t           expected_words [$];

    // crypt table from the lcg, two steps per word, five kinds per row
    initial
    begin
        logic [31:0] s;
        logic [31:0] hi;
        s = shlp_pkg::LCG_START;
        for (int row = 0; row < 256; row++)
        begin
            for (int kind = 0; kind < 5; kind++)
            begin
                s = (s * 32'd125 + 32'd3) % 32'h002A_AAAB;
                hi = {s[15:0], 16'h0000};
                s = (s * 32'd125 + 32'd3) % 32'h002A_AAAB;
                if (kind < 3)
                begin
                    crypt_words[kind][row] = hi | {16'h0000, s[15:0]};
                end
            end
        end
    end

    task automatic restart_hashes();
        for (int k = 0; k < 3; k++)
        begin
            seed_one[k] = shlp_pkg::SEED_ONE_INIT;
            seed_two[k] = shlp_pkg::SEED_TWO_INIT;
        end
    endtask

    task automatic report(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
        fail_count++;
    endtask

    // fold one key byte into the three running hashes
    task automatic fold_byte(logic [7:0] ch);
        logic [31:0] s1;
        logic [31:0] s2;
        if (ch == 8'd0)
        begin
            return;
        end
        for (int k = 0; k < 3; k++)
        begin
            s1 = crypt_words[k][ch] ^ (seed_one[k] + seed_two[k]);
            s2 = {24'd0, ch} + s1 + seed_two[k] + (seed_two[k] << 5) + 32'd3;
            seed_one[k] = s1;
            seed_two[k] = s2;
        end
    endtask

    // expected outcome of one accepted command word
    task automatic predict_word(shlp_pkg::cmd_t c);
        int                span;
        int                pos;
        logic [31:0]       ha;
        logic [31:0]       hb;
        shlp_pkg::result_t r;
        r = '0;
        if (c.func == shlp_pkg::FUNC_NONE)
        begin
            return;
        end
        if (c.func == shlp_pkg::FUNC_CLEAR)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_used[i] = 1'b0;
            end
            restart_hashes();
            r.ok = 1'b1;
            expected_words.push_back(r);
            return;
        end
        fold_byte(c.key_byte);
        if (!c.last_byte)
        begin
            return;
        end
        span = (length_reg == 0) ? 1 : (length_reg > SLOTS) ? SLOTS : int'(length_reg);
        pos = int'(seed_one[0] % 32'(span));
        ha = seed_one[1];
        hb = seed_one[2];
        for (int n = 0; n < span; n++)
        begin
            if (c.func == shlp_pkg::FUNC_INSERT && !slot_used[pos])
            begin
                slot_used[pos] = 1'b1;
                slot_a[pos] = ha;
                slot_b[pos] = hb;
                r.ok = 1'b1;
                r.position = shlp_pkg::POS_W'(pos);
                break;
            end
            if (c.func == shlp_pkg::FUNC_LOOKUP)
            begin
                if (!slot_used[pos])
                begin
                    break;
                end
                if (slot_a[pos] == ha && slot_b[pos] == hb)
                begin
                    r.ok = 1'b1;
                    r.position = shlp_pkg::POS_W'(pos);
                    break;
                end
            end
            pos = (pos + 1) % span;
        end
        restart_hashes();
        expected_words.push_back(r);
    endtask

    // sample all channels at the edge, compare before predicting
    always @(posedge clk or negedge rst_n)
    begin
        shlp_pkg::result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_used[i] = 1'b0;
            end
            restart_hashes();
            length_reg = shlp_pkg::LEN_RESET;
            expected_words.delete();
            fail_count = 0;
            results_seen = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                length_reg = cfg_wdata;
            end
            if (done)
            begin
                results_seen++;
                if (expected_words.size() == 0)
                begin
                    report("unexpected result word, ok", int'(result.ok), -1);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (result.ok !== want.ok)
                    begin
                        report("ok", int'(result.ok), int'(want.ok));
                    end
                    if (result.position !== want.position)
                    begin
                        report("position", int'(result.position), int'(want.position));
                    end
                end
            end
            if (start && !busy)
            begin
                predict_word(cmd);
            end
            pending = expected_words.size();
        end
    end

endmodule

// ----- tb/sv/testbench.sv -----
// testbench: drives key bytes, clears and table lengths into the string hash
// table and gives the verdict; depends on shlp_pkg, the block and hash_table_checker
module testbench;

    localparam int SETTLE = 2200;
    localparam int LIMIT = 20_000_000;

    typedef struct {
        int         n;
        logic [7:0] b [4];
    } key_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    shlp_pkg::cmd_t             cmd = '0;
    logic                       cfg_we = 1'b0;
    logic [shlp_pkg::CFG_W-1:0] cfg_wdata = '0;
    logic                       busy;
    logic                       done;
    shlp_pkg::result_t          result;
    int                         fail_count;
    int                         pending;
    int                         results_seen;
    int                         cycles = 0;
    int                         word_count = 0;
    int                         items = 0;
    int                         length_count = 0;
    int                         idle_pct = 0;
    key_t                       key_pool [$];

    always #1 clk = ~clk;

    string_hash_table_linear_probe dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    hash_table_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .done         (done),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen)
    );

    // cycle limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // one word: hold start until accepted, then idle cycle by cycle at idle_pct
    task automatic send_word(shlp_pkg::func_t f, logic [7:0] b, logic last);
        start <= 1'b1;
        cmd <= '{func: f, key_byte: b, last_byte: last};
        do @(posedge clk); while (busy);
        word_count++;
        if (f != shlp_pkg::FUNC_NONE)
        begin
            items++;
        end
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // a whole key, only the last byte's function counts
    task automatic send_key(shlp_pkg::func_t f, key_t k);
        if (k.n == 0)
        begin
            send_word(f, 8'd0, 1'b1);
            return;
        end
        for (int i = 0; i < k.n; i++)
        begin
            if (i == k.n - 1)
            begin
                send_word(f, k.b[i], 1'b1);
            end
            else
            begin
                send_word($urandom_range(1) ? shlp_pkg::FUNC_INSERT : shlp_pkg::FUNC_LOOKUP,
                          k.b[i], 1'b0);
            end
        end
    endtask

    function automatic key_t random_key();
        key_t k;
        k.n = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4);
        for (int i = 0; i < 4; i++)
        begin
            k.b[i] = ($urandom_range(15) == 0) ? 8'd0 : 8'($urandom);
        end
        return k;
    endfunction

    function automatic key_t pick_key(int reuse_pct);
        key_t k;
        if (key_pool.size() > 0 && $urandom_range(99) < reuse_pct)
        begin
            return key_pool[$urandom_range(key_pool.size() - 1)];
        end
        k = random_key();
        if (key_pool.size() < 12)
        begin
            key_pool.push_back(k);
        end
        else
        begin
            key_pool[$urandom_range(11)] = k;
        end
        return k;
    endfunction

    task automatic wait_drained();
        start <= 1'b0;
        while (pending != 0) @(posedge clk);
    endtask

    // length change only with the block idle and the clear sweep finished
    task automatic write_length(logic [shlp_pkg::CFG_W-1:0] v);
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        while (busy) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        length_count++;
    endtask

    // random mix: inserts and lookups of pooled keys, clears, noise, broken keys
    task automatic run_phase(int n, bit hold_off);
        int   goal;
        int   pick;
        key_t k;
        goal = items + n;
        while (items < goal)
        begin
            pick = $urandom_range(99);
            if (hold_off && items > goal - n / 2)
            begin
                wait_drained();
                hold_off = 1'b0;
            end
            if (pick < 42)
            begin
                send_key(shlp_pkg::FUNC_INSERT, pick_key(65));
            end
            else if (pick < 82)
            begin
                send_key(shlp_pkg::FUNC_LOOKUP, pick_key(70));
            end
            else if (pick < 86)
            begin
                send_word(shlp_pkg::FUNC_CLEAR, 8'($urandom), 1'($urandom));
            end
            else if (pick < 92)
            begin
                send_word(shlp_pkg::FUNC_NONE, 8'($urandom), 1'($urandom));
            end
            else
            begin
                // key cut short by a clear
                k = random_key();
                for (int i = 0; i < k.n; i++)
                begin
                    send_word(shlp_pkg::FUNC_INSERT, k.b[i], 1'b0);
                end
                send_word(shlp_pkg::FUNC_CLEAR, 8'($urandom), 1'b0);
            end
        end
    endtask

    initial
    begin
        key_t k;
        int   lens [10] = '{1, 0, 4, 16, 2047, 7, 64, 1024, 3, 1};
        int   sizes [10] = '{80, 80, 250, 280, 110, 250, 250, 100, 150, 40};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty key, extremes, duplicates, ignored code, clears
        k.n = 0;
        k.b = '{8'd0, 8'd0, 8'd0, 8'd0};
        send_key(shlp_pkg::FUNC_INSERT, k);
        send_key(shlp_pkg::FUNC_LOOKUP, k);
        k.n = 2;
        k.b = '{8'hFF, 8'h01, 8'd0, 8'd0};
        send_key(shlp_pkg::FUNC_LOOKUP, k);
        send_key(shlp_pkg::FUNC_INSERT, k);
        send_key(shlp_pkg::FUNC_LOOKUP, k);
        send_key(shlp_pkg::FUNC_INSERT, k);
        send_word(shlp_pkg::FUNC_NONE, 8'hAA, 1'b1);
        k.n = 3;
        k.b = '{8'h41, 8'h00, 8'h80, 8'd0};
        send_key(shlp_pkg::FUNC_INSERT, k);
        send_key(shlp_pkg::FUNC_LOOKUP, k);
        send_word(shlp_pkg::FUNC_CLEAR, 8'h55, 1'b0);
        send_key(shlp_pkg::FUNC_LOOKUP, k);
        send_word(shlp_pkg::FUNC_INSERT, 8'h7F, 1'b0);
        send_word(shlp_pkg::FUNC_CLEAR, 8'h00, 1'b1);
        send_key(shlp_pkg::FUNC_LOOKUP, k);

        // random phases, sender idling rises and then drops to none over the run
        for (int p = 0; p < 10; p++)
        begin
            idle_pct = (p < 3) ? 26 : (p < 6) ? 77 : 0;
            write_length(shlp_pkg::CFG_W'(lens[p]));
            send_word(shlp_pkg::FUNC_CLEAR, 8'($urandom), 1'b1);
            run_phase(sizes[p], p == 4);
        end

        // drain and settle
        wait_drained();
        repeat (SETTLE) @(posedge clk);

        $display("covered %0d command words over %0d table lengths, %0d results checked",
                 word_count, length_count, results_seen);
        if (pending != 0)
        begin
            $display("%0d expected result words never arrived", pending);
        end
        if (fail_count == 0 && pending == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
